FILE: rtl/core/centered_window_average_assert.svh
// Assertion macros for the centered window average checker
`ifndef CENTERED_WINDOW_AVERAGE_ASSERT_SVH
`define CENTERED_WINDOW_AVERAGE_ASSERT_SVH

// same-cycle implication
`define CWA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("centered_window_average check failed");

// next-cycle implication
`define CWA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("centered_window_average check failed");

`endif

FILE: rtl/core/cwa_pkg.sv
// Shared constants and types of the centered window average block
package cwa_pkg;

    localparam int DATA_W         = 32;
    localparam int SUM_W          = 39;
    localparam int COUNT_W        = 7;
    localparam int RADIUS_W       = 6;
    localparam int DEF_MAX_RADIUS = 32;
    localparam int RADIUS_RESET   = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [DATA_W-1:0]  NO_AVERAGE = {DATA_W{1'b1}};

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SUM   = 5'b00010,
        S_DIV   = 5'b00100,
        S_EMIT  = 5'b01000,
        S_FLUSH = 5'b10000
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } line_req_t;

endpackage

FILE: rtl/core/cwa_line.sv
// Circular delay line holding the samples of the current window
module cwa_line
    import cwa_pkg::*;
#(
    parameter int DEPTH = 2 * DEF_MAX_RADIUS + 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  line_req_t         req,
    input  logic [COUNT_W-1:0] offset,
    input  logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0] rd_data
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PW     = ADDR_W + 1;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] ptr_next;
    logic [ADDR_W-1:0] rd_addr;
    logic [PW-1:0]     ptr_w;
    logic [PW-1:0]     offset_w;
    logic [PW-1:0]     addr_w;
    logic [DATA_W-1:0] rd_data_reg;

    always_comb
    begin
        ptr_w    = {1'b0, ptr_reg};
        offset_w = PW'(offset);
        if (ptr_w >= offset_w)
        begin
            addr_w = ptr_w - offset_w;
        end
        else
        begin
            addr_w = ptr_w + PW'(DEPTH) - offset_w;
        end
        rd_addr = addr_w[ADDR_W-1:0];
        if (ptr_reg == ADDR_W'(DEPTH - 1))
        begin
            ptr_next = '0;
        end
        else
        begin
            ptr_next = ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (req.wr_en)
        begin
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[ptr_reg] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/cwa_div.sv
// Bit-serial signed divider, one quotient bit per cycle, truncating toward zero
module cwa_div
    import cwa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [SUM_W-1:0]  dividend,
    input  logic [COUNT_W-1:0]       divisor,
    output logic                     done,
    output logic [DATA_W-1:0]        quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]   dq_reg;
    logic [SUM_W-1:0]   dq_next;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] rem_next;
    logic [COUNT_W-1:0] dvs_reg;
    logic               neg_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [COUNT_W:0]   trial;
    logic [COUNT_W:0]   diff;
    logic               ge;
    logic [SUM_W-1:0]   mag;
    logic [DATA_W-1:0]  q_mag;

    always_comb
    begin
        mag      = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
        trial    = {rem_reg, dq_reg[SUM_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
        dq_next  = {dq_reg[SUM_W-2:0], ge};
        q_mag    = dq_reg[DATA_W-1:0];
        quotient = neg_reg ? (~q_mag + 1'b1) : q_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= CNT_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                busy_reg <= (cnt_reg != CNT_W'(1));
                done_reg <= (cnt_reg == CNT_W'(1));
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= mag;
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;

endmodule

FILE: rtl/core/centered_window_average.sv
// Top level of the centered window average block
//
// Channels: cfg (valid/ready, radius), in (valid/ready, sample and
// last_sample), out (valid/ready, average, window_full, last_result).
// cfg_ready is high only while the block is idle; a radius write counts only
// between sequences and saturates at MAX_RADIUS. Radius is 1 after reset.
// Each input beat gives at most one result for the position radius samples
// back; the beat flagged last_sample also flushes the remaining positions
// as -1 with window_full low and marks the final result with last_result.
// Flow: a taken beat is summed in S_SUM; a beat with a full window then goes
// through the bit-serial divider, which works on the 39-bit window sum and
// then hands over the quotient, before S_EMIT loads its result. A beat whose
// result is -1 goes from S_SUM to S_EMIT; one that gives no result goes back
// to S_IDLE, or to S_FLUSH if it is the last. Flushed results are loaded one
// by one in S_FLUSH. One beat is worked on at a time.
// The out channel has its own register: a stalled receiver holds the
// pending result and the block still takes the next input beat, but stops
// before it would load a second result.
// Reset clears the window sum, the sample count and out_valid, and returns the block to idle.
module centered_window_average
    import cwa_pkg::*;
#(
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [RADIUS_W-1:0]      radius,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] sample,
    input  logic                     last_sample,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] average,
    output logic                     window_full,
    output logic                     last_result
);

    localparam int DEPTH = 2 * MAX_RADIUS + 1;
    localparam int RAD_W = $clog2(MAX_RADIUS + 1);

    state_t               state_reg;
    state_t               state_next;
    logic [RAD_W-1:0]     radius_reg;
    logic [COUNT_W-1:0]   seen_reg;
    logic [COUNT_W-1:0]   flush_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [DATA_W-1:0]    sample_reg;
    logic                 last_reg;
    logic [DATA_W-1:0]    res_avg_reg;
    logic                 res_full_reg;
    logic                 out_valid_reg;
    logic [DATA_W-1:0]    out_avg_reg;
    logic                 out_full_reg;
    logic                 out_last_reg;

    logic [COUNT_W-1:0]   k_w;
    logic [COUNT_W-1:0]   span;
    logic [COUNT_W-1:0]   win_len;
    logic [COUNT_W-1:0]   after;
    logic [COUNT_W-1:0]   flush_cnt;
    logic signed [SUM_W-1:0] sum_next;
    logic [DATA_W-1:0]    old_sample;
    logic                 in_acc;
    logic                 out_free;
    logic                 is_full;
    logic                 is_partial;
    logic                 drop_old;
    logic                 div_start;
    logic                 div_done;
    logic [DATA_W-1:0]    div_q;
    line_req_t            line_req;

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign average     = out_avg_reg;
    assign window_full = out_full_reg;
    assign last_result = out_last_reg;

    always_comb
    begin
        k_w        = COUNT_W'(radius_reg);
        span       = COUNT_W'({radius_reg, 1'b0});
        win_len    = span + 1'b1;
        is_full    = seen_reg >= span;
        is_partial = seen_reg >= k_w;
        drop_old   = seen_reg >= win_len;
        after      = (seen_reg == COUNT_MAX) ? seen_reg : seen_reg + 1'b1;
        flush_cnt  = (after < k_w) ? after : k_w;
        sum_next   = sum_reg
                   + {{(SUM_W - DATA_W){sample_reg[DATA_W-1]}}, sample_reg}
                   - (drop_old ? {{(SUM_W - DATA_W){old_sample[DATA_W-1]}}, old_sample}
                               : SUM_W'(0));
        line_req.rd_en = in_acc;
        line_req.wr_en = (state_reg == S_SUM);
        div_start      = (state_reg == S_SUM) && is_full;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (is_full)
                begin
                    state_next = S_DIV;
                end
                else if (is_partial)
                begin
                    state_next = S_EMIT;
                end
                else if (last_reg)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (flush_reg != '0) ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (out_free && flush_reg == COUNT_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            radius_reg    <= RAD_W'(RADIUS_RESET);
            seen_reg      <= '0;
            sum_reg       <= '0;
            flush_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready && seen_reg == '0)
            begin
                if (radius > RADIUS_W'(MAX_RADIUS))
                begin
                    radius_reg <= RAD_W'(MAX_RADIUS);
                end
                else
                begin
                    radius_reg <= radius[RAD_W-1:0];
                end
            end
            if (state_reg == S_SUM)
            begin
                sum_reg   <= last_reg ? SUM_W'(0) : sum_next;
                seen_reg  <= last_reg ? COUNT_W'(0) : after;
                flush_reg <= last_reg ? flush_cnt : COUNT_W'(0);
            end
            else if (state_reg == S_FLUSH && out_free)
            begin
                flush_reg <= flush_reg - 1'b1;
            end
            if ((state_reg == S_EMIT || state_reg == S_FLUSH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            sample_reg <= sample;
            last_reg   <= last_sample;
        end
        if (state_reg == S_SUM)
        begin
            res_avg_reg  <= NO_AVERAGE;
            res_full_reg <= 1'b0;
        end
        if (state_reg == S_DIV && div_done)
        begin
            res_avg_reg  <= div_q;
            res_full_reg <= 1'b1;
        end
        if (state_reg == S_EMIT && out_free)
        begin
            out_avg_reg  <= res_avg_reg;
            out_full_reg <= res_full_reg;
            out_last_reg <= last_reg && (flush_reg == '0);
        end
        if (state_reg == S_FLUSH && out_free)
        begin
            out_avg_reg  <= NO_AVERAGE;
            out_full_reg <= 1'b0;
            out_last_reg <= (flush_reg == COUNT_W'(1));
        end
    end

    cwa_line #(
        .DEPTH (DEPTH)
    ) u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (line_req),
        .offset  (win_len),
        .wr_data (sample_reg),
        .rd_data (old_sample)
    );

    cwa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (win_len),
        .done     (div_done),
        .quotient (div_q)
    );

endmodule

FILE: rtl/core/cwa_checker.sv
// Port checker for the centered window average block, bound to the top level
`include "centered_window_average_assert.svh"

module cwa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] average,
    input logic        window_full,
    input logic        last_result
);

    `CWA_ASSERT_IMP(a_partial_is_minus_one, clk, rst_n, out_valid && !window_full, average == 32'hFFFF_FFFF)
    `CWA_ASSERT_NXT(a_busy_after_beat, clk, rst_n, in_valid && in_ready, !in_ready)
    `CWA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(average) && $stable(last_result))
    `CWA_ASSERT_IMP(a_cfg_only_idle, clk, rst_n, cfg_valid && cfg_ready, in_ready)

endmodule

bind centered_window_average cwa_checker u_cwa_checker (.*);
